[sv/lwc_pkg.sv]
// package: widths, types and helper functions of the line window clipper
`timescale 1ns / 1ps
`default_nettype none
package lwc_pkg;
	localparam int FRAC_BITS  = 8;
	localparam int COORD_BITS = 16;
	localparam int REG_BITS   = 12;
	// signed delta and edge distance width
	localparam int DW   = COORD_BITS + 1;
	// magnitude width of a delta or edge distance
	localparam int MAGW = COORD_BITS;
	// dividend width, one divider stage per quotient bit
	localparam int DIVW = MAGW + FRAC_BITS;
	// t in [0, 1.0]
	localparam int TW   = FRAC_BITS + 1;
	// clamped ratio, signed, holds -1 .. 1.0 + 1
	localparam int RW   = FRAC_BITS + 2;
	// product of t and a delta
	localparam int PW   = RW + DW;
	localparam int NEDGE = 4;
	localparam int ADDR_BITS = 4;

	localparam logic [TW-1:0] T_ONE = TW'(1) << FRAC_BITS;

	// register indexes
	localparam logic [1:0] REG_X_MIN = 2'd0;
	localparam logic [1:0] REG_X_MAX = 2'd1;
	localparam logic [1:0] REG_Y_MIN = 2'd2;
	localparam logic [1:0] REG_Y_MAX = 2'd3;

	// edge lanes in test order
	localparam int EDGE_LEFT   = 0;
	localparam int EDGE_RIGHT  = 1;
	localparam int EDGE_TOP    = 2;
	localparam int EDGE_BOTTOM = 3;

	typedef struct packed {
		logic [COORD_BITS-1:0] x0;
		logic [COORD_BITS-1:0] y0;
		logic [COORD_BITS-1:0] x1;
		logic [COORD_BITS-1:0] y1;
		logic [DW-1:0]         dx;
		logic [DW-1:0]         dy;
	} seg_t;

	typedef struct packed {
		logic [DIVW-1:0] n;
		logic [MAGW-1:0] rem;
		logic [MAGW-1:0] d;
		logic            pz;
		logic            pneg;
		logic            qneg;
	} lane_t;

	function automatic logic [MAGW-1:0] abs_mag(input logic [DW-1:0] v);
		logic [DW-1:0] a;
		a = v[DW-1] ? (~v + DW'(1)) : v;
		return a[MAGW-1:0];
	endfunction

	// one restoring division step: one quotient bit
	function automatic lane_t div_step(input lane_t l);
		lane_t         o;
		logic [MAGW:0] sh;
		logic [MAGW:0] df;
		o  = l;
		sh = {l.rem, l.n[DIVW-1]};
		df = sh - {1'b0, l.d};
		if (sh >= {1'b0, l.d}) begin
			o.rem = df[MAGW-1:0];
			o.n   = {l.n[DIVW-2:0], 1'b1};
		end else begin
			o.rem = sh[MAGW-1:0];
			o.n   = {l.n[DIVW-2:0], 1'b0};
		end
		return o;
	endfunction

	// lane setup from signed p and q, then the first step
	function automatic lane_t div_init(input logic [DW-1:0] p, input logic [DW-1:0] q);
		lane_t l;
		l.n    = {abs_mag(q), {FRAC_BITS{1'b0}}};
		l.rem  = '0;
		l.d    = abs_mag(p);
		l.pz   = (p == '0);
		l.pneg = p[DW-1];
		l.qneg = q[DW-1];
		return div_step(l);
	endfunction
endpackage
`default_nettype wire

[sv/lwc_seg_if.sv]
// interfaces: segment input channel and clipped result channel
`timescale 1ns / 1ps
`default_nettype none
interface lwc_seg_in_if;
	import lwc_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] start_x;
	logic [COORD_BITS-1:0] start_y;
	logic [COORD_BITS-1:0] end_x;
	logic [COORD_BITS-1:0] end_y;
	modport source (output valid, start_x, start_y, end_x, end_y, input ready);
	modport sink (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface lwc_seg_out_if;
	import lwc_pkg::*;
	logic                  valid;
	logic                  ready;
	logic                  accepted;
	logic [COORD_BITS-1:0] clip_start_x;
	logic [COORD_BITS-1:0] clip_start_y;
	logic [COORD_BITS-1:0] clip_end_x;
	logic [COORD_BITS-1:0] clip_end_y;
	modport source (output valid, accepted, clip_start_x, clip_start_y, clip_end_x,
		clip_end_y, input ready);
	modport sink (input valid, accepted, clip_start_x, clip_start_y, clip_end_x,
		clip_end_y, output ready);
endinterface
`default_nettype wire

[sv/line_window_clipper.sv]
// top level: pipelined fixed-point line segment clipper against a window
//
// seg carries one segment (start and end points, signed) per item, clip
// returns the clipped segment and an accepted flag, one result per item, in
// order. Both channels use valid/ready. The clip window sits in four 12-bit
// registers on an APB-style port (x_min 0x0, x_max 0x4, y_min 0x8,
// y_max 0xC); write them only while no item is in flight.
// Throughput: one item per cycle unless the receiver stalls. The pipeline is
// one setup stage, 24 divider stages, one bit each,
// set by the width of the quotient, then clamp, edge tests, multiply and
// the output register.
// Reset clears all stage valid bits and loads the window 0..239 x 0..159.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and seg.ready drops; bubbles are not squeezed out. A rejected segment
// comes back unchanged with accepted low.
`timescale 1ns / 1ps
`default_nettype none
module line_window_clipper
	import lwc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [ADDR_BITS-1:0] paddr,
	input  wire logic [31:0]          pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	lwc_seg_in_if.sink                seg,
	lwc_seg_out_if.source             clip
);
	logic [REG_BITS-1:0] x_min_q, x_max_q, y_min_q, y_max_q;
	logic                adv;

	// config registers
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_min_q <= REG_BITS'(0);
			x_max_q <= REG_BITS'(239);
			y_min_q <= REG_BITS'(0);
			y_max_q <= REG_BITS'(159);
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[3:2])
				REG_X_MIN: x_min_q <= pwdata[REG_BITS-1:0];
				REG_X_MAX: x_max_q <= pwdata[REG_BITS-1:0];
				REG_Y_MIN: y_min_q <= pwdata[REG_BITS-1:0];
				REG_Y_MAX: y_max_q <= pwdata[REG_BITS-1:0];
				default: ;
			endcase
		end
	end

	// register read back
	always_comb begin
		unique case (paddr[3:2])
			REG_X_MIN: prdata = 32'(x_min_q);
			REG_X_MAX: prdata = 32'(x_max_q);
			REG_Y_MIN: prdata = 32'(y_min_q);
			REG_Y_MAX: prdata = 32'(y_max_q);
			default:   prdata = '0;
		endcase
	end

	// pipeline moves unless a result waits at the output
	logic vld_s5;
	assign adv       = !vld_s5 || clip.ready;
	assign seg.ready = adv;

	// stage 1: deltas and edge distances
	logic               vld_s1;
	seg_t               seg_s1;
	logic [DW-1:0]      p_s1 [NEDGE];
	logic [DW-1:0]      q_s1 [NEDGE];
	logic [DW-1:0]      x0_w, y0_w, dx_w, dy_w;

	assign x0_w = DW'($signed(seg.start_x));
	assign y0_w = DW'($signed(seg.start_y));
	assign dx_w = DW'($signed(seg.end_x)) - x0_w;
	assign dy_w = DW'($signed(seg.end_y)) - y0_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (adv) vld_s1 <= seg.valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			seg_s1.x0 <= seg.start_x;
			seg_s1.y0 <= seg.start_y;
			seg_s1.x1 <= seg.end_x;
			seg_s1.y1 <= seg.end_y;
			seg_s1.dx <= dx_w;
			seg_s1.dy <= dy_w;
			p_s1[EDGE_LEFT]   <= -dx_w;
			q_s1[EDGE_LEFT]   <= x0_w - DW'(x_min_q);
			p_s1[EDGE_RIGHT]  <= dx_w;
			q_s1[EDGE_RIGHT]  <= DW'(x_max_q) - x0_w;
			p_s1[EDGE_TOP]    <= -dy_w;
			q_s1[EDGE_TOP]    <= y0_w - DW'(y_min_q);
			p_s1[EDGE_BOTTOM] <= dy_w;
			q_s1[EDGE_BOTTOM] <= DW'(y_max_q) - y0_w;
		end
	end

	// divider stages: one quotient bit per stage on each edge lane
	logic  vld_sd [DIVW];
	seg_t  seg_sd [DIVW];
	lane_t lane_sd [DIVW][NEDGE];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DIVW; k++) vld_sd[k] <= 1'b0;
		end else if (adv) begin
			vld_sd[0] <= vld_s1;
			for (int k = 1; k < DIVW; k++) vld_sd[k] <= vld_sd[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			seg_sd[0] <= seg_s1;
			for (int e = 0; e < NEDGE; e++) lane_sd[0][e] <= div_init(p_s1[e], q_s1[e]);
			for (int k = 1; k < DIVW; k++) begin
				seg_sd[k] <= seg_sd[k-1];
				for (int e = 0; e < NEDGE; e++) lane_sd[k][e] <= div_step(lane_sd[k-1][e]);
			end
		end
	end

	// stage 2: sign the ratio and clamp it just outside [0, 1.0]
	logic          vld_s2;
	seg_t          seg_s2;
	logic [RW-1:0] r_s2 [NEDGE];
	logic          pz_s2 [NEDGE];
	logic          pneg_s2 [NEDGE];
	logic          qneg_s2 [NEDGE];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (adv) vld_s2 <= vld_sd[DIVW-1];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			seg_s2 <= seg_sd[DIVW-1];
			for (int e = 0; e < NEDGE; e++) begin
				pz_s2[e]   <= lane_sd[DIVW-1][e].pz;
				pneg_s2[e] <= lane_sd[DIVW-1][e].pneg;
				qneg_s2[e] <= lane_sd[DIVW-1][e].qneg;
				if ((lane_sd[DIVW-1][e].pneg ^ lane_sd[DIVW-1][e].qneg)
						&& lane_sd[DIVW-1][e].n != '0)
					r_s2[e] <= '1;
				else if (lane_sd[DIVW-1][e].n > DIVW'(T_ONE))
					r_s2[e] <= RW'(T_ONE) + RW'(1);
				else
					r_s2[e] <= lane_sd[DIVW-1][e].n[RW-1:0];
			end
		end
	end

	// stage 3: edge tests in order left, right, top, bottom
	logic          vld_s3;
	seg_t          seg_s3;
	logic          ok_s3;
	logic [TW-1:0] t0_s3, t1_s3;
	logic          ok_w;
	logic [RW-1:0] t0_w, t1_w;

	always_comb begin
		ok_w = 1'b1;
		t0_w = '0;
		t1_w = RW'(T_ONE);
		for (int e = 0; e < NEDGE; e++) begin
			if (pz_s2[e]) begin
				if (qneg_s2[e]) ok_w = 1'b0;
			end else if (pneg_s2[e]) begin
				if ($signed(r_s2[e]) > $signed(t1_w)) ok_w = 1'b0;
				else if ($signed(r_s2[e]) > $signed(t0_w)) t0_w = r_s2[e];
			end else begin
				if ($signed(r_s2[e]) < $signed(t0_w)) ok_w = 1'b0;
				else if ($signed(r_s2[e]) < $signed(t1_w)) t1_w = r_s2[e];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else if (adv) vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			seg_s3 <= seg_s2;
			ok_s3  <= ok_w;
			t0_s3  <= t0_w[TW-1:0];
			t1_s3  <= t1_w[TW-1:0];
		end
	end

	// stage 4: t times delta
	logic          vld_s4;
	seg_t          seg_s4;
	logic          ok_s4, mv0_s4, mv1_s4;
	logic [PW-1:0] m0x_s4, m0y_s4, m1x_s4, m1y_s4;
	logic signed [RW-1:0] t0_sg, t1_sg;

	assign t0_sg = $signed({1'b0, t0_s3});
	assign t1_sg = $signed({1'b0, t1_s3});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else if (adv) vld_s4 <= vld_s3;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			seg_s4 <= seg_s3;
			ok_s4  <= ok_s3;
			mv0_s4 <= (t0_s3 != '0);
			mv1_s4 <= (t1_s3 != T_ONE);
			m0x_s4 <= PW'(t0_sg * $signed(seg_s3.dx));
			m0y_s4 <= PW'(t0_sg * $signed(seg_s3.dy));
			m1x_s4 <= PW'(t1_sg * $signed(seg_s3.dx));
			m1y_s4 <= PW'(t1_sg * $signed(seg_s3.dy));
		end
	end

	// stage 5: move the points from the original start, output register
	logic                  acc_s5;
	logic [COORD_BITS-1:0] sx_s5, sy_s5, ex_s5, ey_s5;
	logic [PW-1:0]         nsx_w, nsy_w, nex_w, ney_w;

	assign nsx_w = PW'($signed(seg_s4.x0)) + PW'($signed(m0x_s4) >>> FRAC_BITS);
	assign nsy_w = PW'($signed(seg_s4.y0)) + PW'($signed(m0y_s4) >>> FRAC_BITS);
	assign nex_w = PW'($signed(seg_s4.x0)) + PW'($signed(m1x_s4) >>> FRAC_BITS);
	assign ney_w = PW'($signed(seg_s4.y0)) + PW'($signed(m1y_s4) >>> FRAC_BITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s5 <= 1'b0;
		else if (adv) vld_s5 <= vld_s4;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			acc_s5 <= ok_s4;
			sx_s5  <= (ok_s4 && mv0_s4) ? nsx_w[COORD_BITS-1:0] : seg_s4.x0;
			sy_s5  <= (ok_s4 && mv0_s4) ? nsy_w[COORD_BITS-1:0] : seg_s4.y0;
			ex_s5  <= (ok_s4 && mv1_s4) ? nex_w[COORD_BITS-1:0] : seg_s4.x1;
			ey_s5  <= (ok_s4 && mv1_s4) ? ney_w[COORD_BITS-1:0] : seg_s4.y1;
		end
	end

	assign clip.valid        = vld_s5;
	assign clip.accepted     = acc_s5;
	assign clip.clip_start_x = sx_s5;
	assign clip.clip_start_y = sy_s5;
	assign clip.clip_end_x   = ex_s5;
	assign clip.clip_end_y   = ey_s5;
endmodule
`default_nettype wire

[tb/tb_line_window_clipper.sv]
// testbench: line window clipper checked against a fixed-point clipping predictor
`timescale 1ns / 1ps
`default_nettype none
module tb_line_window_clipper;
	import lwc_pkg::*;

	localparam int QUIET_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		logic [COORD_BITS-1:0] sx;
		logic [COORD_BITS-1:0] sy;
		logic [COORD_BITS-1:0] ex;
		logic [COORD_BITS-1:0] ey;
	} segment_t;

	typedef struct packed {
		logic                  acc;
		logic [COORD_BITS-1:0] sx;
		logic [COORD_BITS-1:0] sy;
		logic [COORD_BITS-1:0] ex;
		logic [COORD_BITS-1:0] ey;
	} clipped_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [ADDR_BITS-1:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;

	lwc_seg_in_if seg ();
	lwc_seg_out_if clip ();

	line_window_clipper u_dut (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.seg(seg.sink), .clip(clip.source)
	);

	// window copy used by the predictor
	logic [REG_BITS-1:0] win_x_min, win_x_max, win_y_min, win_y_max;

	segment_t pending_segs[$];
	clipped_t clipped_expected[$];
	int send_idle_pct, recv_idle_pct;
	int hold_off_cycles;
	bit hold_off_req;
	int quiet_cycles;
	bit failed;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// one edge test on t bounds; returns 0 when the segment is rejected
	function automatic bit edge_narrow(input longint p, input longint q,
		inout longint t0, inout longint t1);
		longint r;
		if (p == 0) return q >= 0;
		r = (q * (longint'(1) << FRAC_BITS)) / p;
		if (p < 0) begin
			if (r > t1) return 0;
			if (r > t0) t0 = r;
		end else begin
			if (r < t0) return 0;
			if (r < t1) t1 = r;
		end
		return 1;
	endfunction

	function automatic clipped_t clip_segment(input segment_t s);
		clipped_t c;
		longint x0, y0, x1, y1, dx, dy, t0, t1;
		bit ok;
		x0 = longint'($signed(s.sx));
		y0 = longint'($signed(s.sy));
		x1 = longint'($signed(s.ex));
		y1 = longint'($signed(s.ey));
		dx = x1 - x0;
		dy = y1 - y0;
		t0 = 0;
		t1 = longint'(1) << FRAC_BITS;
		c = {1'b0, s.sx, s.sy, s.ex, s.ey};
		ok = edge_narrow(-dx, x0 - longint'(win_x_min), t0, t1);
		if (ok) ok = edge_narrow(dx, longint'(win_x_max) - x0, t0, t1);
		if (ok) ok = edge_narrow(-dy, y0 - longint'(win_y_min), t0, t1);
		if (ok) ok = edge_narrow(dy, longint'(win_y_max) - y0, t0, t1);
		if (ok) begin
			c.acc = 1'b1;
			// >>> on longint floors, matching the arithmetic shift
			if (t1 < (longint'(1) << FRAC_BITS)) begin
				c.ex = COORD_BITS'(x0 + ((t1 * dx) >>> FRAC_BITS));
				c.ey = COORD_BITS'(y0 + ((t1 * dy) >>> FRAC_BITS));
			end
			if (t0 > 0) begin
				c.sx = COORD_BITS'(x0 + ((t0 * dx) >>> FRAC_BITS));
				c.sy = COORD_BITS'(y0 + ((t0 * dy) >>> FRAC_BITS));
			end
		end
		return c;
	endfunction

	// driver: offers queued segments, idles at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg.valid <= 1'b0;
			seg.start_x <= '0;
			seg.start_y <= '0;
			seg.end_x <= '0;
			seg.end_y <= '0;
		end else if (!seg.valid || seg.ready) begin
			if (seg.valid) clipped_expected.push_back(clip_segment(
				{seg.start_x, seg.start_y, seg.end_x, seg.end_y}));
			if (pending_segs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				segment_t s;
				s = pending_segs.pop_front();
				seg.valid <= 1'b1;
				seg.start_x <= s.sx;
				seg.start_y <= s.sy;
				seg.end_x <= s.ex;
				seg.end_y <= s.ey;
			end else begin
				seg.valid <= 1'b0;
			end
		end
	end

	// monitor: checks each result item, drives ready with random stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip.ready <= 1'b0;
			hold_off_cycles <= 0;
		end else begin
			if (clip.valid && clip.ready) begin
				clipped_t got, want;
				got = {clip.accepted, clip.clip_start_x, clip.clip_start_y,
					clip.clip_end_x, clip.clip_end_y};
				if (clipped_expected.size() == 0) begin
					$error("result item with nothing expected");
					failed <= 1'b1;
				end else begin
					want = clipped_expected.pop_front();
					if (got.acc !== want.acc) begin
						$error("accepted: expected %0d got %0d", want.acc, got.acc);
						failed <= 1'b1;
					end
					if (got.sx !== want.sx) begin
						$error("clip_start_x: expected %0d got %0d", $signed(want.sx), $signed(got.sx));
						failed <= 1'b1;
					end
					if (got.sy !== want.sy) begin
						$error("clip_start_y: expected %0d got %0d", $signed(want.sy), $signed(got.sy));
						failed <= 1'b1;
					end
					if (got.ex !== want.ex) begin
						$error("clip_end_x: expected %0d got %0d", $signed(want.ex), $signed(got.ex));
						failed <= 1'b1;
					end
					if (got.ey !== want.ey) begin
						$error("clip_end_y: expected %0d got %0d", $signed(want.ey), $signed(got.ey));
						failed <= 1'b1;
					end
				end
			end
			// long hold-off so the pipeline fills and stalls its input
			if (hold_off_req && hold_off_cycles == 0) begin
				hold_off_cycles <= 300;
				clip.ready <= 1'b0;
			end else if (hold_off_cycles > 1) begin
				hold_off_cycles <= hold_off_cycles - 1;
				clip.ready <= 1'b0;
			end else begin
				if (hold_off_cycles == 1) hold_off_cycles <= -1;
				clip.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (!arst_n || (seg.valid && seg.ready) || (clip.valid && clip.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("line_window_clipper: mismatch");
			$finish;
		end
	end

	task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= ADDR_BITS'({idx, 2'b00}); pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			REG_X_MIN: win_x_min = value[REG_BITS-1:0];
			REG_X_MAX: win_x_max = value[REG_BITS-1:0];
			REG_Y_MIN: win_y_min = value[REG_BITS-1:0];
			default:   win_y_max = value[REG_BITS-1:0];
		endcase
	endtask

	task automatic set_window(input logic [31:0] x0, input logic [31:0] x1,
		input logic [31:0] y0, input logic [31:0] y1);
		reg_write(REG_X_MIN, x0);
		reg_write(REG_X_MAX, x1);
		reg_write(REG_Y_MIN, y0);
		reg_write(REG_Y_MAX, y1);
	endtask

	task automatic queue_seg(input int sx, input int sy, input int ex, input int ey);
		pending_segs.push_back({COORD_BITS'(sx), COORD_BITS'(sy),
			COORD_BITS'(ex), COORD_BITS'(ey)});
	endtask

	// coordinate mostly near the window, sometimes anywhere
	function automatic int pick_coord(input int lo, input int hi);
		case ($urandom_range(9))
			0, 1: return int'($signed(16'($urandom)));
			2: return $urandom_range(1) ? 32767 : -32768;
			default: return $urandom_range(hi + 200, 0) + lo - 100;
		endcase
	endfunction

	task automatic queue_random(input int n);
		repeat (n) queue_seg(pick_coord(win_x_min, win_x_max), pick_coord(win_y_min, win_y_max),
			pick_coord(win_x_min, win_x_max), pick_coord(win_y_min, win_y_max));
	endtask

	// wait until every queued item has come back, then drain the pipe
	task automatic wait_idle();
		while (pending_segs.size() > 0 || seg.valid || clipped_expected.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		win_x_min = 0; win_x_max = 239; win_y_min = 0; win_y_max = 159;
		send_idle_pct = 18; recv_idle_pct = 62;
		hold_off_req = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset window, inside, outside, crossing, degenerate, extremes
		queue_seg(10, 10, 100, 100);
		queue_seg(-50, 80, 300, 80);
		queue_seg(120, -40, 120, 200);
		queue_seg(-100, -100, 400, 300);
		queue_seg(300, 10, 400, 10);
		queue_seg(-10, 50, -10, 90);
		queue_seg(50, 50, 50, 50);
		queue_seg(500, 50, 500, 50);
		queue_seg(0, 0, 239, 159);
		queue_seg(-32768, -32768, 32767, 32767);
		queue_seg(32767, -32768, -32768, 32767);
		queue_seg(-32768, 0, -32768, 32767);
		queue_seg(300, 200, -20, -30);
		queue_seg(239, 159, 240, 160);
		queue_seg(-1, -1, 0, 0);
		queue_random(300);
		wait_idle();

		// inverted window rejects all
		set_window(200, 100, 150, 20);
		queue_seg(150, 80, 150, 80);
		queue_seg(-500, -500, 500, 500);
		queue_random(80);
		wait_idle();

		// full range window with high write bits set
		set_window(32'hFFFF_F000, 32'hFFFF_FFFF, 0, 4095);
		send_idle_pct = 62; recv_idle_pct = 18;
		queue_seg(-32768, -32768, 32767, 32767);
		queue_seg(4095, 4095, 4096, 4096);
		queue_random(300);
		wait_idle();

		// single point window
		set_window(4095, 4095, 4095, 4095);
		queue_seg(4095, 4095, 4095, 4095);
		queue_seg(4000, 4000, 4200, 4200);
		queue_random(100);
		wait_idle();

		// mid window, no idling, one long receiver hold-off
		set_window(100, 900, 50, 700);
		send_idle_pct = 0; recv_idle_pct = 0;
		hold_off_req = 1'b1;
		queue_random(500);
		wait_idle();

		set_window(0, 239, 0, 159);
		queue_random(320);
		wait_idle();

		if (!failed)
			$display("line_window_clipper: match");
		else
			$display("line_window_clipper: mismatch");
		$finish;
	end
endmodule
`default_nettype wire
